### hdl/lip_pkg.sv
// ---------------------------------------------------------------------------
// lip_pkg
// Shared types and constants of the lossless inverse predictor.
// ---------------------------------------------------------------------------
package lip_pkg;

    localparam int PIX_W  = 32;
    localparam int MODE_W = 4;
    localparam int CFG_W  = 13;
    localparam int USER_W = 5;

    typedef logic [PIX_W-1:0]  t_pixel;
    typedef logic [MODE_W-1:0] t_mode;

    // Opaque black, used for the very first pixel and for mode 0.
    localparam t_pixel ARGB_BLACK = 32'hff00_0000;

    // Predictor modes; 14 and 15 fall back to black.
    localparam t_mode MODE_BLACK      = 4'd0;
    localparam t_mode MODE_L          = 4'd1;
    localparam t_mode MODE_T          = 4'd2;
    localparam t_mode MODE_TR         = 4'd3;
    localparam t_mode MODE_TL         = 4'd4;
    localparam t_mode MODE_AVG_LTR_T  = 4'd5;
    localparam t_mode MODE_AVG_L_TL   = 4'd6;
    localparam t_mode MODE_AVG_L_T    = 4'd7;
    localparam t_mode MODE_AVG_TL_T   = 4'd8;
    localparam t_mode MODE_AVG_T_TR   = 4'd9;
    localparam t_mode MODE_AVG4       = 4'd10;
    localparam t_mode MODE_SELECT     = 4'd11;
    localparam t_mode MODE_GRAD_FULL  = 4'd12;
    localparam t_mode MODE_GRAD_HALF  = 4'd13;

    // Neighbourhood of the pixel being rebuilt.
    typedef struct packed {
        t_pixel left;
        t_pixel top;
        t_pixel top_left;
        t_pixel top_right;
    } t_nbr;

endpackage

### hdl/lip_ram.sv
// ---------------------------------------------------------------------------
// lip_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ---------------------------------------------------------------------------
module lip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/lip_predict.sv
// ---------------------------------------------------------------------------
// lip_predict
// Per-channel predictor for all 14 modes, plus the modulo-256 add of the
// residual.
// ---------------------------------------------------------------------------
module lip_predict (
    input  lip_pkg::t_mode  i_mode,
    input  lip_pkg::t_nbr   i_nbr,
    input  lip_pkg::t_pixel i_residual,
    output lip_pkg::t_pixel o_pixel
);

    function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8:1];
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [9:0] v);
        logic [7:0] r;
        if (v < 10'sd0) begin
            r = 8'd0;
        end else if (v > 10'sd255) begin
            r = 8'hff;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    logic [3:0][7:0] m5, m6, m7, m8, m9, m10, m12, m13;
    logic [3:0][7:0] ad_tc, ad_lc;
    logic [9:0]      sum_tc, sum_lc;
    lip_pkg::t_pixel pred;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [7:0]        l, t, c, d;
        logic signed [9:0] grad;
        logic signed [8:0] diff;
        logic signed [8:0] half;
        logic signed [9:0] gsum;

        assign l = i_nbr.left[8*g +: 8];
        assign t = i_nbr.top[8*g +: 8];
        assign c = i_nbr.top_left[8*g +: 8];
        assign d = i_nbr.top_right[8*g +: 8];

        assign m5[g]  = avg2(avg2(l, d), t);
        assign m6[g]  = avg2(l, c);
        assign m7[g]  = avg2(l, t);
        assign m8[g]  = avg2(c, t);
        assign m9[g]  = avg2(t, d);
        assign m10[g] = avg2(avg2(l, c), avg2(t, d));

        assign grad   = $signed({2'b00, l}) + $signed({2'b00, t}) - $signed({2'b00, c});
        assign m12[g] = clamp8(grad);

        // halving rounds toward zero: bias negatives by one before the shift
        assign diff   = $signed({1'b0, m7[g]}) - $signed({1'b0, c});
        assign half   = diff[8] ? ((diff + 9'sd1) >>> 1) : (diff >>> 1);
        assign gsum   = $signed({2'b00, m7[g]}) + 10'(half);
        assign m13[g] = clamp8(gsum);

        assign ad_tc[g] = (t > c) ? (t - c) : (c - t);
        assign ad_lc[g] = (l > c) ? (l - c) : (c - l);
    end

    assign sum_tc = 10'(ad_tc[0]) + 10'(ad_tc[1]) + 10'(ad_tc[2]) + 10'(ad_tc[3]);
    assign sum_lc = 10'(ad_lc[0]) + 10'(ad_lc[1]) + 10'(ad_lc[2]) + 10'(ad_lc[3]);

    always_comb begin
        unique case (i_mode)
            lip_pkg::MODE_BLACK:     pred = lip_pkg::ARGB_BLACK;
            lip_pkg::MODE_L:         pred = i_nbr.left;
            lip_pkg::MODE_T:         pred = i_nbr.top;
            lip_pkg::MODE_TR:        pred = i_nbr.top_right;
            lip_pkg::MODE_TL:        pred = i_nbr.top_left;
            lip_pkg::MODE_AVG_LTR_T: pred = m5;
            lip_pkg::MODE_AVG_L_TL:  pred = m6;
            lip_pkg::MODE_AVG_L_T:   pred = m7;
            lip_pkg::MODE_AVG_TL_T:  pred = m8;
            lip_pkg::MODE_AVG_T_TR:  pred = m9;
            lip_pkg::MODE_AVG4:      pred = m10;
            lip_pkg::MODE_SELECT:    pred = (sum_tc < sum_lc) ? i_nbr.left : i_nbr.top;
            lip_pkg::MODE_GRAD_FULL: pred = m12;
            lip_pkg::MODE_GRAD_HALF: pred = m13;
            default:                 pred = lip_pkg::ARGB_BLACK;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_pixel[8*k +: 8] = i_residual[8*k +: 8] + pred[8*k +: 8];
        end
    end

endmodule

### hdl/lossless_inverse_predictor_core.sv
// ---------------------------------------------------------------------------
// lossless_inverse_predictor_core
// Inverse predictor of lossless ARGB images: residual + prediction per
// channel, with the previous row held in a line buffer.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  s       | in        | i_s_tvalid/o_s_tready | tdata residual, tuser mode+start
//  m       | out       | o_m_tvalid/i_m_tready | tdata pixel, tlast row_end
//  cfg     | in        | i_cfg_valid/o_cfg_ready | image_width (13 bits)
//
//  One pixel per clock sustained while the m side does not stall. An accepted
//  pixel goes straight into the output register; the critical path is
//  line-buffer read register -> predictor -> channel add -> output register,
//  with the left pixel fed back from the same add.
//  Reset (synchronous, i_rst_n low) clears position, flags, width (=1) and
//  the output valid; the line buffer needs no clearing.
//  The s side takes a beat whenever the output register is empty or drains in
//  the same cycle, so an m-side stall stalls s by one register only.
//
//  Line buffer: two RAM copies written with the same pixel. When pixel c is
//  accepted, copy A fetches column c+1 (next T) and copy B column c+2 (next
//  TR). Column 0 of any row equals the saved row-first pixel, so a row or
//  image restart never waits on the RAM.
// ---------------------------------------------------------------------------
module lossless_inverse_predictor_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // [31:0] residual
    input  logic [4:0]  i_s_tuser,    // [3:0] mode, [4] start_image
    // stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [31:0] pixel
    output logic        o_m_tlast,    // row_end
    // config
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data    // [12:0] image_width
);

    localparam int AW = $clog2(MAX_WIDTH);       // column / RAM address
    localparam int WW = $clog2(MAX_WIDTH + 1);   // width, can hold MAX_WIDTH

    // position and neighbour state
    logic [AW-1:0]   r_col,        n_col;
    logic            r_first_row,  n_first_row;
    lip_pkg::t_pixel r_left;
    lip_pkg::t_pixel r_row_first;
    lip_pkg::t_pixel r_upper_left;
    logic [WW-1:0]   r_width,      n_width;

    // output register
    logic            r_m_valid;
    lip_pkg::t_pixel r_m_pixel;
    logic            r_m_last;

    logic            s_fire;
    logic            start;
    logic [AW-1:0]   col_pre, col;
    logic            first_pre, first;
    logic            wrap, last, col_zero;
    lip_pkg::t_mode  eff_mode;
    lip_pkg::t_nbr   nbr;
    lip_pkg::t_pixel ram_t, ram_tr, px;
    logic [31:0]     cfg_wide;

    assign o_s_tready  = !r_m_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign start       = i_s_tuser[4];

    // Resolve this beat's raster position: start mark, then the case of a
    // width that shrank below the current column (new row, not row 0).
    always_comb begin
        col_pre   = start ? '0 : r_col;
        first_pre = start ? 1'b1 : r_first_row;
        wrap      = (WW'(col_pre) >= r_width);
        col       = wrap ? '0 : col_pre;
        first     = wrap ? 1'b0 : first_pre;
        last      = (WW'(col) == (r_width - WW'(1)));
        col_zero  = (col == '0);
    end

    // Border rules override the tile mode.
    always_comb begin
        if (first && col_zero) begin
            eff_mode = lip_pkg::MODE_BLACK;
        end else if (first) begin
            eff_mode = lip_pkg::MODE_L;
        end else if (col_zero) begin
            eff_mode = lip_pkg::MODE_T;
        end else begin
            eff_mode = i_s_tuser[3:0];
        end
    end

    assign nbr.left      = r_left;
    assign nbr.top       = col_zero ? r_row_first : ram_t;
    assign nbr.top_left  = r_upper_left;
    assign nbr.top_right = last ? r_row_first : ram_tr;   // last column wraps

    lip_predict u_predict (
        .i_mode     (eff_mode),
        .i_nbr      (nbr),
        .i_residual (i_s_tdata),
        .o_pixel    (px)
    );

    // line buffer, copy A: top of the next pixel
    lip_ram #(
        .WIDTH (lip_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_top (
        .i_clk   (i_clk),
        .i_we    (s_fire),
        .i_waddr (col),
        .i_wdata (px),
        .i_re    (s_fire),
        .i_raddr (col + AW'(1)),
        .o_rdata (ram_t)
    );

    // line buffer, copy B: top-right of the next pixel
    lip_ram #(
        .WIDTH (lip_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_tr (
        .i_clk   (i_clk),
        .i_we    (s_fire),
        .i_waddr (col),
        .i_wdata (px),
        .i_re    (s_fire),
        .i_raddr (col + AW'(2)),
        .o_rdata (ram_tr)
    );

    // width register: 0 acts as 1, oversize clamps to MAX_WIDTH
    assign cfg_wide = 32'(i_cfg_data);
    always_comb begin
        n_width = r_width;
        if (i_cfg_valid) begin
            if (cfg_wide == 32'd0) begin
                n_width = WW'(1);
            end else if (cfg_wide > 32'(MAX_WIDTH)) begin
                n_width = WW'(MAX_WIDTH);
            end else begin
                n_width = WW'(cfg_wide);
            end
        end
    end

    always_comb begin
        n_col       = r_col;
        n_first_row = r_first_row;
        if (s_fire) begin
            n_col       = last ? '0 : (col + AW'(1));
            n_first_row = last ? 1'b0 : first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_first_row  <= 1'b1;
            r_width      <= WW'(1);
            r_m_valid    <= 1'b0;
            r_left       <= '0;
            r_row_first  <= '0;
            r_upper_left <= '0;
        end else begin
            r_col       <= n_col;
            r_first_row <= n_first_row;
            r_width     <= n_width;
            if (s_fire) begin
                r_m_valid    <= 1'b1;
                r_left       <= px;
                r_upper_left <= nbr.top;
                if (col_zero) begin
                    r_row_first <= px;
                end
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload of the output register
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_m_pixel <= px;
            r_m_last  <= last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_pixel;
    assign o_m_tlast  = r_m_last;

endmodule

### hdl/lip_checker.sv
// ---------------------------------------------------------------------------
// lip_checker
// Port-level checks of the inverse predictor core, bound to the top level.
// ---------------------------------------------------------------------------
module lip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    // a waiting result is never overwritten by a new input beat
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted over a stalled result");

    // every accepted input beat yields a result beat next cycle
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted pixel produced no result");

    // no result appears without an input beat behind it
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !(i_s_tvalid && o_s_tready) |=> !o_m_tvalid)
        else $error("result repeated or invented");

endmodule

bind lossless_inverse_predictor_core lip_checker u_lip_checker (.*);
